/* hw/rtl/itl_pkg.sv */
// Shared types and constants for the interpolated table lookup core.
// Depends on nothing; every other file of the block imports it.
package itl_pkg;

  localparam int IndexW = 6;
  localparam int ValueW = 16;
  localparam int CountW = 7;
  localparam int StatusW = 2;
  localparam int QuotW = 16;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef enum logic [StatusW-1:0] {
    STATUS_IN_RANGE = 2'd0,
    STATUS_BELOW    = 2'd1,
    STATUS_ABOVE    = 2'd2
  } status_t;

endpackage

/* hw/rtl/itl_if.sv */
// Valid/ready item channels of the interpolated table lookup core.
// Depends on itl_pkg for the fixed field widths.
interface itl_in_if #(
  parameter int POSITION_BITS = 16
);
  import itl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [IndexW-1:0]        entry_index;
  logic [POSITION_BITS-1:0] entry_position;
  logic signed [ValueW-1:0] entry_value;
  logic [POSITION_BITS-1:0] query_position;

  modport source (
    output valid, operation, entry_index, entry_position, entry_value, query_position,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_position, entry_value, query_position,
    output ready
  );
endinterface

interface itl_out_if;
  import itl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] result_value;
  logic [StatusW-1:0]       range_status;

  modport source (output valid, result_value, range_status, input ready);
  modport sink (input valid, result_value, range_status, output ready);
endinterface

/* hw/rtl/interpolated_table_lookup_core.sv */
// Piecewise-linear lookup over a table of (position, value) pairs held in one synchronous
// memory. A write item stores one entry. A query item scans the table from entry 0,
// one entry per cycle through the memory's single read port, for the first position
// at or above the query; when it must interpolate between two entries, it then
// multiplies once and runs a 16-step radix-2 divider. One item is worked on at a
// time; a finished result waits in the output register.
// Depends on itl_pkg and the channels in itl_if.
module interpolated_table_lookup_core #(
  parameter int TABLE_DEPTH   = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  itl_in_if.sink                            in_item,
  itl_out_if.source                         out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [itl_pkg::ApbAddrW-1:0]      paddr,
  input  logic [itl_pkg::ApbDataW-1:0]      pwdata,
  output logic [itl_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);
  import itl_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int PB    = POSITION_BITS;
  localparam int WordW = PB + ValueW;
  localparam int CntW  = $clog2(QuotW);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_MULT   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CountW-1:0]  entries_in_use;
  logic [WordW-1:0]   table_mem [TABLE_DEPTH];
  logic [WordW-1:0]   rd_data;
  logic [AW-1:0]      issue_idx;
  logic [AW-1:0]      cmp_idx;
  logic               cmp_valid;
  logic [AW-1:0]      last_idx;
  logic [PB-1:0]      q;
  logic [PB-1:0]      prev_pos;
  logic [ValueW-1:0]  prev_val;
  logic [ValueW-1:0]  v0;
  logic [QuotW-1:0]   mag;
  logic               neg;
  logic [PB-1:0]      dq;
  logic [PB-1:0]      dp;
  logic [PB-1:0]      rem;
  logic [QuotW-1:0]   lo;
  logic [CntW-1:0]    div_cnt;
  logic [ValueW-1:0]  fin_value;
  status_t            fin_status;

  logic               in_acc;
  logic               cfg_wr;
  logic [PB-1:0]      rd_pos;
  logic [ValueW-1:0]  rd_val;
  logic               hit;
  logic               scan_end;
  logic               interp;
  logic [ValueW:0]    dv;
  logic [ValueW:0]    dv_abs;
  logic [PB:0]        trial;
  logic               ge;
  logic [PB-1:0]      rem_next;
  logic [QuotW-1:0]   lo_next;
  logic [ValueW:0]    quot_signed;
  logic [ValueW:0]    sum;
  logic [AW-1:0]      last_idx_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES_IN_USE);
  assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? ApbDataW'(entries_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CountW'(1);
    end else if (cfg_wr) begin
      entries_in_use <= pwdata[CountW-1:0];
    end
  end

  assign in_item.ready = (state == ST_IDLE);
  assign in_acc        = in_item.valid && in_item.ready;

  always_ff @(posedge clk) begin
    if (in_acc && (in_item.operation == OP_WRITE)
        && (32'(in_item.entry_index) < TABLE_DEPTH)) begin
      table_mem[AW'(in_item.entry_index)] <= {in_item.entry_position, in_item.entry_value};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= table_mem[issue_idx];
  end

  assign rd_pos   = rd_data[WordW-1:ValueW];
  assign rd_val   = rd_data[ValueW-1:0];
  assign hit      = cmp_valid && (q <= rd_pos);
  assign scan_end = cmp_valid && (cmp_idx == last_idx);
  assign interp   = hit && (cmp_idx != '0) && (q != rd_pos);

  assign dv     = {rd_val[ValueW-1], rd_val} - {prev_val[ValueW-1], prev_val};
  assign dv_abs = dv[ValueW] ? -dv : dv;

  always_comb begin
    if (entries_in_use == '0) begin
      last_idx_next = '0;
    end else if (32'(entries_in_use) > TABLE_DEPTH) begin
      last_idx_next = AW'(TABLE_DEPTH - 1);
    end else begin
      last_idx_next = AW'(entries_in_use - CountW'(1));
    end
  end

  assign trial       = {rem, lo[QuotW-1]};
  assign ge          = (trial >= {1'b0, dp});
  assign rem_next    = ge ? PB'(trial - {1'b0, dp}) : trial[PB-1:0];
  assign lo_next     = {lo[QuotW-2:0], ge};
  assign quot_signed = neg ? -{1'b0, lo_next} : {1'b0, lo_next};
  assign sum         = {v0[ValueW-1], v0} + quot_signed;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (in_item.operation == OP_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (interp) begin
          state_next = ST_MULT;
        end else if (hit || scan_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_MULT: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == CntW'(QuotW - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_item.valid || out_item.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cmp_valid      <= 1'b0;
      issue_idx      <= '0;
      div_cnt        <= '0;
      out_item.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        issue_idx <= '0;
        cmp_valid <= 1'b0;
      end else if (state == ST_SCAN) begin
        issue_idx <= issue_idx + AW'(1);
        cmp_valid <= 1'b1;
      end
      if (state == ST_MULT) begin
        div_cnt <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + CntW'(1);
      end
      if (state == ST_FINISH && (!out_item.valid || out_item.ready)) begin
        out_item.valid <= 1'b1;
      end else if (out_item.ready) begin
        out_item.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q        <= in_item.query_position;
      last_idx <= last_idx_next;
    end
    if (state == ST_SCAN) begin
      cmp_idx <= issue_idx;
      if (cmp_valid) begin
        prev_pos <= rd_pos;
        prev_val <= rd_val;
      end
      if (interp) begin
        v0  <= prev_val;
        neg <= dv[ValueW];
        mag <= dv_abs[QuotW-1:0];
        dq  <= q - prev_pos;
        dp  <= rd_pos - prev_pos;
      end else if (hit) begin
        fin_value  <= rd_val;
        fin_status <= ((cmp_idx == '0) && (q < rd_pos)) ? STATUS_BELOW : STATUS_IN_RANGE;
      end else if (scan_end) begin
        fin_value  <= rd_val;
        fin_status <= STATUS_ABOVE;
      end
    end
    if (state == ST_MULT) begin
      {rem, lo} <= (PB + QuotW)'(mag) * (PB + QuotW)'(dq);
    end
    if (state == ST_DIV) begin
      rem <= rem_next;
      lo  <= lo_next;
      if (div_cnt == CntW'(QuotW - 1)) begin
        fin_value  <= sum[ValueW-1:0];
        fin_status <= STATUS_IN_RANGE;
      end
    end
    if (state == ST_FINISH && (!out_item.valid || out_item.ready)) begin
      out_item.result_value <= fin_value;
      out_item.range_status <= fin_status;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < dp))
    else $error("divider remainder reached the divisor");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cmp_valid) |-> (cmp_idx <= last_idx))
    else $error("table scan ran past the last entry in use");

  assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.operation == OP_WRITE) |=> !$rose(out_item.valid))
    else $error("write item produced a result");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_item.valid) |-> $past(state == ST_FINISH))
    else $error("result presented without a finished lookup");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for interpolated_table_lookup_core: directed corner items, then
// random tables and queries, checked against an in-bench interpolation predictor.
// Depends on itl_pkg, the channels in itl_if and the core itself.
module tb_top;
  import itl_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 24;
  localparam int ITEM_TARGET = 1750;
  localparam int MAX_PRINTED = 50;
  localparam logic [ApbAddrW-1:0] ENTRIES_ADDR = ApbAddrW'(4 * REG_ENTRIES_IN_USE);

  typedef struct {
    logic signed [ValueW-1:0] value;
    status_t                  status;
  } lookup_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  itl_in_if #(.POSITION_BITS(16)) in_ch ();
  itl_out_if out_ch ();

  interpolated_table_lookup_core #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .POSITION_BITS(16)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_ch),
    .out_item(out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [15:0]              position_copy [TABLE_DEPTH];
  logic signed [ValueW-1:0] value_copy [TABLE_DEPTH];
  int unsigned              entries_cfg = 1;
  lookup_t                  lookups_due [$];
  int                       items_sent = 0;
  int                       error_count = 0;
  bit                       sender_gaps = 1'b1;
  bit                       receiver_stalls = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic int effective_count();
    int n;
    n = entries_cfg;
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic lookup_t interpolate_lookup(input logic [15:0] q);
    lookup_t r;
    int n;
    int hit;
    longint p0, p1, v0, v1, num;
    n = effective_count();
    hit = -1;
    for (int i = 0; i < n; i++) begin
      if (hit < 0 && q <= position_copy[i]) hit = i;
    end
    r.status = STATUS_IN_RANGE;
    if (hit < 0) begin
      r.value = value_copy[n-1];
      r.status = STATUS_ABOVE;
    end else if (hit == 0) begin
      r.value = value_copy[0];
      if (q < position_copy[0]) r.status = STATUS_BELOW;
    end else if (q == position_copy[hit]) begin
      r.value = value_copy[hit];
    end else begin
      p0 = longint'(position_copy[hit-1]);
      p1 = longint'(position_copy[hit]);
      v0 = longint'(value_copy[hit-1]);
      v1 = longint'(value_copy[hit]);
      num = (v1 - v0) * (longint'(q) - p0);
      r.value = 16'(v0 + num / (p1 - p0));
    end
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [IndexW-1:0] idx,
                           input logic [15:0] pos, input logic [15:0] val,
                           input logic [15:0] q);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    if (op == OP_WRITE) begin
      in_ch.entry_index <= idx;
      in_ch.entry_position <= pos;
      in_ch.entry_value <= val;
      in_ch.query_position <= 16'($urandom);
    end else begin
      in_ch.entry_index <= 6'($urandom);
      in_ch.entry_position <= 16'($urandom);
      in_ch.entry_value <= 16'($urandom);
      in_ch.query_position <= q;
    end
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (op == OP_WRITE) begin
      position_copy[idx] = pos;
      value_copy[idx] = val;
    end else begin
      lookups_due.push_back(interpolate_lookup(q));
    end
    items_sent++;
  endtask

  task automatic stop_and_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_entry_count(input int unsigned count);
    stop_and_drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ENTRIES_ADDR;
    pwdata <= 32'(count);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    entries_cfg = count & 7'h7F;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== 32'(entries_cfg)) begin
      flag_mismatch($sformatf("entry count read back %0d, wrote %0d", prdata, entries_cfg));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_sorted_table();
    int step_max;
    int pos;
    step_max = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 16) : $urandom_range(17, 1040);
    pos = $urandom_range(0, 65535 - 63 * step_max);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      send_item(OP_WRITE, 6'(k), 16'(pos), 16'($urandom), 16'h0);
      pos += $urandom_range(0, step_max);
    end
  endtask

  function automatic logic [15:0] pick_query();
    int j;
    logic [15:0] lo, hi;
    j = $urandom_range(0, effective_count() - 1);
    lo = (j == 0) ? 16'h0 : position_copy[j-1];
    hi = position_copy[j];
    case ($urandom_range(0, 6))
      0: return 16'($urandom);
      1: return position_copy[j];
      2: return position_copy[j] + 16'($urandom_range(0, 2)) - 16'd1;
      3: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      default: begin
        if (hi > lo) return lo + 16'($urandom_range(0, hi - lo));
        return hi;
      end
    endcase
  endfunction

  task automatic test_reset_count();
    send_item(OP_WRITE, 6'd0, 16'h1000, 16'sd100, 16'h0);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'hFFFF);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h0000);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h1000);
  endtask

  task automatic test_directed_corners();
    program_entry_count(4);
    send_item(OP_WRITE, 6'd1, 16'h3000, 16'h8000, 16'h0);
    send_item(OP_WRITE, 6'd2, 16'h8000, 16'h7FFF, 16'h0);
    send_item(OP_WRITE, 6'd3, 16'hFFFF, 16'hFFFF, 16'h0);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h0000);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h1000);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h2000);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h3000);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h3001);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h7FFF);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'hFFFE);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'hFFFF);
    program_entry_count(3);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'hFFFF);
    program_entry_count(0);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h8000);
    program_entry_count(4);
    send_item(OP_WRITE, 6'd1, 16'h0100, 16'sd5, 16'h0);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h2000);
    send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, 16'h0800);
  endtask

  task automatic test_random_tables();
    int phase_no;
    int count;
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: count = 1;
        1: count = TABLE_DEPTH;
        2: count = 0;
        3: count = $urandom_range(TABLE_DEPTH + 1, 127);
        default: count = $urandom_range(2, TABLE_DEPTH);
      endcase
      program_entry_count(count);
      sender_gaps = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      if (phase_no == 0 || $urandom_range(0, 2) == 0) begin
        load_sorted_table();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(OP_WRITE, 6'($urandom), 16'($urandom), 16'($urandom), 16'h0);
        end
      end
      repeat ($urandom_range(30, 90)) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(OP_WRITE, 6'($urandom), 16'($urandom), 16'($urandom), 16'h0);
        end else begin
          send_item(OP_QUERY, 6'd0, 16'h0, 16'h0, pick_query());
        end
      end
      phase_no++;
    end
  endtask

  initial begin : result_checker
    lookup_t due;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = receiver_stalls ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      if (lookups_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d status %0d with no query outstanding",
                                out_ch.result_value, out_ch.range_status));
      end else begin
        due = lookups_due.pop_front();
        if (out_ch.result_value !== due.value) begin
          flag_mismatch($sformatf("result_value %0d, expected %0d",
                                  out_ch.result_value, due.value));
        end
        if (out_ch.range_status !== due.status) begin
          flag_mismatch($sformatf("range_status %0d, expected %0d",
                                  out_ch.range_status, due.status));
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_WRITE;
    in_ch.entry_index <= '0;
    in_ch.entry_position <= '0;
    in_ch.entry_value <= '0;
    in_ch.query_position <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_count();
    test_directed_corners();
    test_random_tables();
    stop_and_drain();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/itl_pkg.sv
hw/rtl/itl_if.sv
hw/rtl/interpolated_table_lookup_core.sv
bench/tb_top.sv
